/* hdl/arpm_pkg.sv */
// Shared constants and types of the ADC RMS / peak meter.
package arpm_pkg;

  localparam int unsigned RAW_W       = 16;
  localparam int unsigned ERR_BIT     = 15;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned SQ_W        = 2 * SAMPLE_W;
  localparam int unsigned SUM_W       = 42;
  localparam int unsigned WC_W        = 20;
  localparam int unsigned ERR_W       = 32;
  localparam int unsigned DIV_W       = 42;
  localparam int unsigned ROUND_W     = 5;
  localparam int unsigned OUT_FIELD_W = 2 * SAMPLE_W + WC_W + ERR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [SAMPLE_W-1:0] MIDSCALE      = SAMPLE_W'(2048);
  localparam logic [ROUND_W-1:0]  NEWTON_ROUNDS = ROUND_W'(16);

  // tuser kind codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MEAN  = 5'b00010,
    ST_ROOT  = 5'b00100,
    ST_RWAIT = 5'b01000,
    ST_OUT   = 5'b10000
  } back_state_e;

endpackage

/* hdl/adc_rms_peak_meter.sv */
// Windowed RMS / peak meter for a 12-bit ADC stream (top level).
// Samples: one transaction per cycle unless a report waits on a full queue, folded into
//   the window in the cycle after acceptance. Report: snapshot queued (2 deep); the back
//   end then divides sum by count and runs up to 16 Newton rounds, each a division on the
//   shared bit-serial divider; samples flow on until a report meets a full queue.
// Reset (rst_ni, async, low): window, error count, queue and result valid clear.
module adc_rms_peak_meter #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [arpm_pkg::RAW_W-1:0]         s_axis_tdata_i,  // [15:0] raw_sample
  input  logic                               s_axis_tuser_i,  // [0] operation
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [11:0] rms_value, [23:12] peak_value, [43:24] window_count, [75:44] error_total,
  // [79:76] zero
  output logic [arpm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned ENTRY_W = arpm_pkg::SUM_W + COUNT_BITS + arpm_pkg::SAMPLE_W
                                    + arpm_pkg::ERR_W;

  logic                          push, pop, q_full, q_empty;
  logic [arpm_pkg::SUM_W-1:0]    snap_sum, q_sum;
  logic [COUNT_BITS-1:0]         snap_cnt, q_cnt;
  logic [arpm_pkg::SAMPLE_W-1:0] snap_peak, q_peak;
  logic [arpm_pkg::ERR_W-1:0]    snap_err, q_err;
  logic [ENTRY_W-1:0]            q_wdata, q_rdata;

  logic [arpm_pkg::SAMPLE_W-1:0] rms, peak;
  logic [arpm_pkg::WC_W-1:0]     wc;
  logic [arpm_pkg::ERR_W-1:0]    err;

  // Front: sample stage, window accumulators, report snapshot.
  arpm_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .raw_i       (s_axis_tdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .snap_sum_o  (snap_sum),
    .snap_cnt_o  (snap_cnt),
    .snap_peak_o (snap_peak),
    .snap_err_o  (snap_err)
  );

  assign q_wdata = {snap_err, snap_peak, snap_cnt, snap_sum};
  assign {q_err, q_peak, q_cnt, q_sum} = q_rdata;

  // Closed windows wait here while the root is worked out.
  arpm_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: mean, Newton root, result register.
  arpm_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .q_sum_i   (q_sum),
    .q_cnt_i   (q_cnt),
    .q_peak_i  (q_peak),
    .q_err_i   (q_err),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .rms_o     (rms),
    .peak_o    (peak),
    .wc_o      (wc),
    .err_o     (err)
  );

  assign m_axis_tdata_o = {(arpm_pkg::OUT_TDATA_W - arpm_pkg::OUT_FIELD_W)'(0),
                           err, wc, peak, rms};

endmodule

/* hdl/arpm_front.sv */
// Front end: takes stream transactions, folds samples into the window, snapshots on report.
module arpm_front #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic                            op_i,
  input  logic [arpm_pkg::RAW_W-1:0]      raw_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output logic [arpm_pkg::SUM_W-1:0]      snap_sum_o,
  output logic [COUNT_BITS-1:0]           snap_cnt_o,
  output logic [arpm_pkg::SAMPLE_W-1:0]   snap_peak_o,
  output logic [arpm_pkg::ERR_W-1:0]      snap_err_o
);

  logic                          st_valid_q, st_valid_d;
  logic                          st_op_q, st_err_q;
  logic [arpm_pkg::SAMPLE_W-1:0] st_mag_q;
  logic [arpm_pkg::SQ_W-1:0]     st_sq_q;

  logic [arpm_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [COUNT_BITS-1:0]         cnt_q, cnt_d;
  logic [arpm_pkg::SAMPLE_W-1:0] peak_q, peak_d;
  logic [arpm_pkg::ERR_W-1:0]    err_q, err_d;

  logic                          advance, take;
  logic [arpm_pkg::SAMPLE_W-1:0] conv, mag;
  logic [arpm_pkg::SUM_W:0]      sum_ext;

  // a report waits in the stage while the queue is full
  assign advance   = st_valid_q && !(st_op_q == arpm_pkg::OP_REPORT && q_full_i);
  assign s_ready_o = !st_valid_q || advance;
  assign take      = s_valid_i && s_ready_o;
  assign push_o    = advance && (st_op_q == arpm_pkg::OP_REPORT);

  assign conv = raw_i[arpm_pkg::SAMPLE_W-1:0];
  assign mag  = (conv >= arpm_pkg::MIDSCALE) ? conv - arpm_pkg::MIDSCALE
                                             : arpm_pkg::MIDSCALE - conv;

  assign sum_ext = {1'b0, sum_q} + (arpm_pkg::SUM_W + 1)'(st_sq_q);

  always_comb begin
    st_valid_d = st_valid_q;
    if (take) begin
      st_valid_d = 1'b1;
    end else if (advance) begin
      st_valid_d = 1'b0;
    end
  end

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    peak_d = peak_q;
    err_d  = err_q;
    if (advance) begin
      if (st_op_q == arpm_pkg::OP_REPORT) begin
        sum_d  = '0;
        cnt_d  = '0;
        peak_d = '0;
      end else begin
        // saturate on carry out of the sum
        sum_d = sum_ext[arpm_pkg::SUM_W] ? '1 : sum_ext[arpm_pkg::SUM_W-1:0];
        if (cnt_q != '1) begin
          cnt_d = cnt_q + COUNT_BITS'(1);
        end
        if (st_mag_q > peak_q) begin
          peak_d = st_mag_q;
        end
        if (st_err_q) begin
          err_d = err_q + arpm_pkg::ERR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
      peak_q     <= '0;
      err_q      <= '0;
    end else begin
      st_valid_q <= st_valid_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      peak_q     <= peak_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      st_op_q  <= op_i;
      st_err_q <= raw_i[arpm_pkg::ERR_BIT];
      st_mag_q <= mag;
      st_sq_q  <= arpm_pkg::SQ_W'(mag) * arpm_pkg::SQ_W'(mag);
    end
  end

  assign snap_sum_o  = sum_q;
  assign snap_cnt_o  = cnt_q;
  assign snap_peak_o = peak_q;
  assign snap_err_o  = err_q;

endmodule

/* hdl/arpm_fifo.sv */
// Two-entry queue between front and back ends.
module arpm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/arpm_div.sv */
// Restoring divider, one quotient bit per cycle.
module arpm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [arpm_pkg::DIV_W-1:0]   dividend_i,
  input  logic [arpm_pkg::DIV_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [arpm_pkg::DIV_W-1:0]   quot_o
);

  localparam int unsigned STEP_W = $clog2(arpm_pkg::DIV_W);

  logic                         busy_q, done_q;
  logic [STEP_W-1:0]            step_q;
  logic [arpm_pkg::DIV_W-1:0]   rem_q, quo_q, den_q;
  logic [arpm_pkg::DIV_W:0]     shifted, diff;
  logic                         ge;

  assign shifted = {rem_q, quo_q[arpm_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(arpm_pkg::DIV_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[arpm_pkg::DIV_W-1:0] : shifted[arpm_pkg::DIV_W-1:0];
      quo_q <= {quo_q[arpm_pkg::DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* hdl/arpm_back.sv */
// Back end: mean by division, Newton square root, result register.
module arpm_back #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  output logic                           pop_o,
  input  logic [arpm_pkg::SUM_W-1:0]     q_sum_i,
  input  logic [COUNT_BITS-1:0]          q_cnt_i,
  input  logic [arpm_pkg::SAMPLE_W-1:0]  q_peak_i,
  input  logic [arpm_pkg::ERR_W-1:0]     q_err_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [arpm_pkg::SAMPLE_W-1:0]  rms_o,
  output logic [arpm_pkg::SAMPLE_W-1:0]  peak_o,
  output logic [arpm_pkg::WC_W-1:0]      wc_o,
  output logic [arpm_pkg::ERR_W-1:0]     err_o
);

  arpm_pkg::back_state_e state_q, state_d;

  logic [arpm_pkg::SAMPLE_W-1:0] peak_q;
  logic [arpm_pkg::WC_W-1:0]     wc_q, wc_in;
  logic [arpm_pkg::ERR_W-1:0]    err_q;
  logic [arpm_pkg::DIV_W-1:0]    mean_q, x_q;
  logic [arpm_pkg::ROUND_W-1:0]  round_q;
  logic                          out_valid_q;

  logic                          div_start, div_done;
  logic [arpm_pkg::DIV_W-1:0]    div_num, div_den, div_quot;
  logic [arpm_pkg::DIV_W:0]      next_sum;
  logic [arpm_pkg::DIV_W-1:0]    x_next;
  logic                          load_out;

  // window count clipped to the result field
  if (COUNT_BITS > arpm_pkg::WC_W) begin : g_wc_sat
    assign wc_in = (|q_cnt_i[COUNT_BITS-1:arpm_pkg::WC_W]) ? '1
                                                          : q_cnt_i[arpm_pkg::WC_W-1:0];
  end else begin : g_wc_ext
    assign wc_in = arpm_pkg::WC_W'(q_cnt_i);
  end

  assign next_sum = {1'b0, div_quot} + {1'b0, x_q};
  assign x_next   = next_sum[arpm_pkg::DIV_W:1];

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = mean_q;
    div_den   = x_q;
    load_out  = 1'b0;
    unique case (state_q)
      arpm_pkg::ST_IDLE: begin
        div_num = q_sum_i;
        div_den = arpm_pkg::DIV_W'(q_cnt_i);
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (q_cnt_i == '0) begin
            state_d = arpm_pkg::ST_ROOT;
          end else begin
            div_start = 1'b1;
            state_d   = arpm_pkg::ST_MEAN;
          end
        end
      end
      arpm_pkg::ST_MEAN: begin
        if (div_done) begin
          state_d = arpm_pkg::ST_ROOT;
        end
      end
      arpm_pkg::ST_ROOT: begin
        if (x_q == '0 || round_q == arpm_pkg::NEWTON_ROUNDS) begin
          state_d = arpm_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = arpm_pkg::ST_RWAIT;
        end
      end
      arpm_pkg::ST_RWAIT: begin
        if (div_done) begin
          state_d = (x_next == x_q) ? arpm_pkg::ST_OUT : arpm_pkg::ST_ROOT;
        end
      end
      arpm_pkg::ST_OUT: begin
        if (!out_valid_q || m_ready_i) begin
          load_out = 1'b1;
          state_d  = arpm_pkg::ST_IDLE;
        end
      end
      default: state_d = arpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      peak_q  <= q_peak_i;
      wc_q    <= wc_in;
      err_q   <= q_err_i;
      mean_q  <= '0;
      x_q     <= arpm_pkg::DIV_W'(arpm_pkg::MIDSCALE);
      round_q <= '0;
    end else if (state_q == arpm_pkg::ST_MEAN && div_done) begin
      mean_q <= div_quot;
    end else if (state_q == arpm_pkg::ST_RWAIT && div_done) begin
      x_q     <= x_next;
      round_q <= round_q + arpm_pkg::ROUND_W'(1);
    end
    if (load_out) begin
      rms_o  <= x_q[arpm_pkg::SAMPLE_W-1:0];
      peak_o <= peak_q;
      wc_o   <= wc_q;
      err_o  <= err_q;
    end
  end

  assign m_valid_o = out_valid_q;

  arpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule

/* hdl/arpm_checker.sv */
// Port-level checks of the meter, bound to the top level.
module arpm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_valid_i,
  input logic                             m_ready_i,
  input logic [arpm_pkg::OUT_TDATA_W-1:0] m_data_i
);

  logic [arpm_pkg::SAMPLE_W-1:0] rms, peak;
  logic [arpm_pkg::WC_W-1:0]     wc;

  assign rms  = m_data_i[arpm_pkg::SAMPLE_W-1:0];
  assign peak = m_data_i[2*arpm_pkg::SAMPLE_W-1:arpm_pkg::SAMPLE_W];
  assign wc   = m_data_i[2*arpm_pkg::SAMPLE_W+arpm_pkg::WC_W-1:2*arpm_pkg::SAMPLE_W];

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i)
    else $error("result valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> $stable(m_data_i))
    else $error("result changed while stalled");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> peak <= arpm_pkg::MIDSCALE)
    else $error("peak beyond half scale");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && wc == '0 |-> rms == '0 && peak == '0)
    else $error("empty window reports nonzero level");

endmodule

bind adc_rms_peak_meter arpm_checker u_arpm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_data_i  (m_axis_tdata_o)
);
